// ===== hw/rtl/ssla_pkg.sv =====
// Package for the sorted set linked array unit.
// Holds microcode word type, control codes and the control store contents.
// Used by sorted_set_linked_array_unit; no dependencies.
package ssla_pkg;

    localparam int STEP_W = 5;

    typedef logic [STEP_W-1:0] step_t;

    // action codes on the input beat
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_BAD    = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_BAD,
        C_ACT_RD,
        C_ACT_RM,
        C_INS_STOP,
        C_RM_STOP,
        C_NX_EQ,
        C_NX_ZERO,
        C_RD_ZERO
    } cond_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_ITEM_NX,
        W_X_ITEM,
        W_X_RD
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        E_ZERO,
        E_ITEM,
        E_NX
    } emit_src_t;

    typedef enum logic {
        L_ONE,
        L_RD_ZERO
    } last_src_t;

    typedef struct packed {
        logic      take;
        logic      rd_en;
        logic      walk;
        wr_op_t    wr;
        cnt_op_t   cnt;
        logic      emit;
        emit_src_t esrc;
        status_t   est;
        last_src_t elast;
        cond_t     cond;
        step_t     target;
    } uword_t;

    // program addresses
    localparam step_t S_IDLE  = 5'd0;
    localparam step_t S_CHK   = 5'd1;
    localparam step_t S_DRD   = 5'd2;
    localparam step_t S_DRM   = 5'd3;
    localparam step_t S_IW    = 5'd4;
    localparam step_t S_IDEC  = 5'd5;
    localparam step_t S_I1    = 5'd6;
    localparam step_t S_I2    = 5'd7;
    localparam step_t S_DUP   = 5'd8;
    localparam step_t S_ERR   = 5'd9;
    localparam step_t S_RMW   = 5'd10;
    localparam step_t S_RDEC  = 5'd11;
    localparam step_t S_R1    = 5'd12;
    localparam step_t S_R2    = 5'd13;
    localparam step_t S_RD0   = 5'd14;
    localparam step_t S_RDL   = 5'd15;
    localparam step_t S_EMPTY = 5'd16;

    localparam uword_t UW_NOP = '{
        take:   1'b0,
        rd_en:  1'b0,
        walk:   1'b0,
        wr:     W_NONE,
        cnt:    CNT_KEEP,
        emit:   1'b0,
        esrc:   E_ZERO,
        est:    ST_DONE,
        elast:  L_ONE,
        cond:   C_NEVER,
        target: S_IDLE
    };

    // Control store. A step branches to target when cond holds, otherwise
    // falls through, except a walk step which repeats and advances one link.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = UW_NOP;
        case (s)
            S_IDLE:
            begin
                w.take   = 1'b1;
                w.cond   = C_NO_BEAT;
                w.target = S_IDLE;
            end
            S_CHK:
            begin
                w.rd_en  = 1'b1;
                w.cond   = C_BAD;
                w.target = S_ERR;
            end
            S_DRD:
            begin
                w.rd_en  = 1'b1;
                w.cond   = C_ACT_RD;
                w.target = S_RD0;
            end
            S_DRM:
            begin
                w.rd_en  = 1'b1;
                w.cond   = C_ACT_RM;
                w.target = S_RMW;
            end
            S_IW:
            begin
                w.walk   = 1'b1;
                w.cond   = C_INS_STOP;
                w.target = S_IDEC;
            end
            S_IDEC:
            begin
                w.cond   = C_NX_EQ;
                w.target = S_DUP;
            end
            S_I1:
            begin
                w.wr  = W_ITEM_NX;
                w.cnt = CNT_INC;
            end
            S_I2:
            begin
                w.wr     = W_X_ITEM;
                w.emit   = 1'b1;
                w.esrc   = E_ITEM;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_DUP:
            begin
                w.emit   = 1'b1;
                w.est    = ST_MISS;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_ERR:
            begin
                w.emit   = 1'b1;
                w.est    = ST_RANGE;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_RMW:
            begin
                w.walk   = 1'b1;
                w.cond   = C_RM_STOP;
                w.target = S_RDEC;
            end
            S_RDEC:
            begin
                w.cond   = C_NX_ZERO;
                w.target = S_DUP;
            end
            S_R1:
            begin
                w.wr  = W_X_RD;
                w.cnt = CNT_DEC;
            end
            S_R2:
            begin
                w.emit   = 1'b1;
                w.esrc   = E_ITEM;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_RD0:
            begin
                w.cond   = C_NX_ZERO;
                w.target = S_EMPTY;
            end
            S_RDL:
            begin
                w.walk   = 1'b1;
                w.emit   = 1'b1;
                w.esrc   = E_NX;
                w.elast  = L_RD_ZERO;
                w.cond   = C_RD_ZERO;
                w.target = S_IDLE;
            end
            S_EMPTY:
            begin
                w.emit   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ssla_ram.sv =====
// Generic single write, single read RAM with registered read data.
// Read data holds while read enable is low. No dependencies.
module ssla_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sorted_set_linked_array_unit.sv =====
// Top level of the sorted set linked array unit.
// Depends on ssla_pkg and ssla_ram.
//
// Keeps distinct items 1..MAX_ITEM as an ascending linked list whose links
// sit in one RAM indexed by item, with the head link in a register. A small
// microcode program steps a plain datapath. One input beat is taken at a
// time and the walk follows one link per clock, except that a readout walk
// waits while its previous beat is held by a stalled output. An insert or
// remove walks to the place of its item, a bad request goes straight to
// its result, and readout loads one beat per item as it walks. The next
// input beat is taken in the cycle after the final result is loaded.
// Every insert, remove or bad request gives one result beat; readout gives
// one beat per item (one beat with item zero for an empty list), with last
// on the final beat. A new input beat is taken while the last result still
// waits in the output register.
module sorted_set_linked_array_unit #(
    parameter int MAX_ITEM = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [$clog2(MAX_ITEM+1)-1:0]       item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [$clog2(MAX_ITEM+1)-1:0]       result_item,
    output logic [1:0]                          status,
    output logic                                last,
    output logic [$clog2(MAX_ITEM+1)-1:0]       item_count
);

    localparam int ITEM_W = $clog2(MAX_ITEM + 1);
    localparam logic [ITEM_W-1:0] MAX_VAL = ITEM_W'(MAX_ITEM);

    ssla_pkg::step_t   upc_reg, upc_next;
    ssla_pkg::uword_t  uw;

    logic [1:0]        act_reg;
    logic [ITEM_W-1:0] item_reg;
    logic [ITEM_W-1:0] x_reg;
    logic [ITEM_W-1:0] nx_reg;
    logic [ITEM_W-1:0] head_reg;
    logic [ITEM_W-1:0] count_reg;

    logic              out_valid_reg;
    logic [ITEM_W-1:0] res_item_reg;
    logic [1:0]        status_reg;
    logic              last_reg;
    logic [ITEM_W-1:0] res_count_reg;

    logic [ITEM_W-1:0] rd_data;
    logic [ITEM_W-1:0] rd_addr;
    logic              rd_en;
    logic              ram_we;
    logic [ITEM_W-1:0] wr_addr;
    logic [ITEM_W-1:0] wr_data;
    logic              wr_any;

    logic              frozen;
    logic              cond_true;
    logic              walk_go;
    logic              take_beat;
    logic              bad;

    assign uw = ssla_pkg::ucode(upc_reg);

    assign in_stall  = !uw.take;
    assign take_beat = uw.take && in_valid;

    // an emitting step waits while the previous result is still held
    assign frozen = uw.emit && out_valid_reg && out_stall;

    assign bad = (act_reg == ssla_pkg::ACT_BAD)
              || ((act_reg != ssla_pkg::ACT_READ)
                  && ((item_reg == '0) || (item_reg > MAX_VAL)));

    always_comb
    begin
        case (uw.cond)
            ssla_pkg::C_NEVER:    cond_true = 1'b0;
            ssla_pkg::C_ALWAYS:   cond_true = 1'b1;
            ssla_pkg::C_NO_BEAT:  cond_true = !in_valid;
            ssla_pkg::C_BAD:      cond_true = bad;
            ssla_pkg::C_ACT_RD:   cond_true = (act_reg == ssla_pkg::ACT_READ);
            ssla_pkg::C_ACT_RM:   cond_true = (act_reg == ssla_pkg::ACT_REMOVE);
            ssla_pkg::C_INS_STOP: cond_true = (nx_reg == '0) || (nx_reg >= item_reg);
            ssla_pkg::C_RM_STOP:  cond_true = (nx_reg == '0) || (nx_reg == item_reg);
            ssla_pkg::C_NX_EQ:    cond_true = (nx_reg == item_reg);
            ssla_pkg::C_NX_ZERO:  cond_true = (nx_reg == '0);
            ssla_pkg::C_RD_ZERO:  cond_true = (rd_data == '0);
            default:              cond_true = 1'b1;
        endcase
    end

    assign walk_go = uw.walk && !cond_true && !frozen;

    always_comb
    begin
        if (frozen)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = uw.target;
        end
        else if (uw.walk)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // walking reads the link of the entry just fetched
    assign rd_en   = (uw.rd_en && !frozen) || walk_go;
    assign rd_addr = uw.walk ? rd_data : nx_reg;

    always_comb
    begin
        wr_any  = !frozen;
        wr_addr = x_reg;
        wr_data = item_reg;
        case (uw.wr)
            ssla_pkg::W_ITEM_NX:
            begin
                wr_addr = item_reg;
                wr_data = nx_reg;
            end
            ssla_pkg::W_X_ITEM:
            begin
                wr_addr = x_reg;
                wr_data = item_reg;
            end
            ssla_pkg::W_X_RD:
            begin
                wr_addr = x_reg;
                wr_data = rd_data;
            end
            default:
            begin
                wr_any = 1'b0;
            end
        endcase
    end

    // address zero is the head link, kept in a register
    assign ram_we = wr_any && (wr_addr != '0);

    ssla_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (MAX_ITEM + 1)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ssla_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (wr_any && (wr_addr == '0))
            begin
                head_reg <= wr_data;
            end
            if (!frozen)
            begin
                case (uw.cnt)
                    ssla_pkg::CNT_INC: count_reg <= count_reg + 1'b1;
                    ssla_pkg::CNT_DEC: count_reg <= count_reg - 1'b1;
                    default:           count_reg <= count_reg;
                endcase
            end
            if (uw.emit && !frozen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_beat)
        begin
            act_reg  <= action;
            item_reg <= item;
            x_reg    <= '0;
            nx_reg   <= head_reg;
        end
        else if (walk_go)
        begin
            x_reg  <= nx_reg;
            nx_reg <= rd_data;
        end
        if (uw.emit && !frozen)
        begin
            case (uw.esrc)
                ssla_pkg::E_ITEM: res_item_reg <= item_reg;
                ssla_pkg::E_NX:   res_item_reg <= nx_reg;
                default:          res_item_reg <= '0;
            endcase
            status_reg    <= uw.est;
            last_reg      <= (uw.elast == ssla_pkg::L_ONE) || (rd_data == '0);
            res_count_reg <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_item = res_item_reg;
    assign status      = status_reg;
    assign last        = last_reg;
    assign item_count  = res_count_reg;

endmodule
